/* src/svf_pkg.sv */
`timescale 1ns / 1ps
// shared types, register map and q31 helpers of the state-variable filter
package svf_pkg;

    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_CUTOFF    = 3'd0;
    localparam logic [2:0] REG_DAMP_MANT = 3'd1;
    localparam logic [2:0] REG_DAMP_SHFT = 3'd2;
    localparam logic [2:0] REG_GAIN_LP   = 3'd3;
    localparam logic [2:0] REG_GAIN_HP   = 3'd4;
    localparam logic [2:0] REG_GAIN_BP   = 3'd5;
    localparam logic [2:0] REG_GAIN_NT   = 3'd6;
    localparam logic [2:0] REG_MODE      = 3'd7;

    // output selector codes, upper bits of output_mode
    localparam logic [2:0] SEL_LOW   = 3'd1;
    localparam logic [2:0] SEL_HIGH  = 3'd2;
    localparam logic [2:0] SEL_BAND  = 3'd3;
    localparam logic [2:0] SEL_NOTCH = 3'd4;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_ASR = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic signed [31:0] cutoff_coeff;
        logic [30:0]        damping_mantissa;
        logic [4:0]         damping_shift;
        logic signed [31:0] gain_lowpass;
        logic signed [31:0] gain_highpass;
        logic signed [31:0] gain_bandpass;
        logic signed [31:0] gain_notch;
        logic [3:0]         output_mode;
    } cfg_t;

    // clamp a 33 bit value to the signed 32 bit range
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* src/svf_regs.sv */
`timescale 1ns / 1ps
// apb register file holding the filter coefficients and output mode
module svf_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [svf_pkg::APB_AW-1:0] paddr,
    input  logic [svf_pkg::APB_DW-1:0] pwdata,
    output logic [svf_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output svf_pkg::cfg_t              cfg
);
    import svf_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_CUTOFF:    cfg_next.cutoff_coeff     = pwdata;
                REG_DAMP_MANT: cfg_next.damping_mantissa = pwdata[30:0];
                REG_DAMP_SHFT: cfg_next.damping_shift    = pwdata[4:0];
                REG_GAIN_LP:   cfg_next.gain_lowpass     = pwdata;
                REG_GAIN_HP:   cfg_next.gain_highpass    = pwdata;
                REG_GAIN_BP:   cfg_next.gain_bandpass    = pwdata;
                REG_GAIN_NT:   cfg_next.gain_notch       = pwdata;
                REG_MODE:      cfg_next.output_mode      = pwdata[3:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CUTOFF:    prdata = cfg_reg.cutoff_coeff;
            REG_DAMP_MANT: prdata = {1'b0, cfg_reg.damping_mantissa};
            REG_DAMP_SHFT: prdata = {27'd0, cfg_reg.damping_shift};
            REG_GAIN_LP:   prdata = cfg_reg.gain_lowpass;
            REG_GAIN_HP:   prdata = cfg_reg.gain_highpass;
            REG_GAIN_BP:   prdata = cfg_reg.gain_bandpass;
            REG_GAIN_NT:   prdata = cfg_reg.gain_notch;
            REG_MODE:      prdata = {28'd0, cfg_reg.output_mode};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/svf_alu.sv */
`timescale 1ns / 1ps
// shared q31 unit: saturating multiply, add, subtract and arithmetic shift
module svf_alu (
    input  svf_pkg::alu_op_t   op,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] res
);
    import svf_pkg::*;

    logic signed [63:0] prod;
    logic signed [32:0] sum;
    logic signed [32:0] diff;

    assign prod = a * b;
    assign sum  = {a[31], a} + {b[31], b};
    assign diff = {a[31], a} - {b[31], b};

    always_comb
    begin
        unique case (op)
            OP_MUL:  res = sat33(prod[63:31]);
            OP_ADD:  res = sat33(sum);
            OP_SUB:  res = sat33(diff);
            OP_ASR:  res = a >>> b[4:0];
            default: res = a;
        endcase
    end

endmodule

/* src/state_variable_filter_q31.sv */
`timescale 1ns / 1ps
// chamberlin state-variable filter, q31, one shared arithmetic unit
//
//  channel   dir  signals                               word
//  s_axis    in   s_axis_tvalid/tready/tdata[31:0]      sample_in
//  m_axis    out  m_axis_tvalid/tready/tdata[31:0]      sample_out
//  apb       cfg  psel/penable/pwrite/paddr[4:0]/pwdata  8 registers at 4*i
//
// every arithmetic step goes through the one multiply/add/shift unit, one
// step per cycle: an iteration is 8 steps, a single tap 1 step, the mix 8 steps
// s_axis_tready is high only while the sequencer is idle
// the result sits in an output register, so a new word is taken while the
// previous result waits; the sequencer holds in its last step if it is full
// reset clears the filter state, the registers and the sequencer
module state_variable_filter_q31 (
    input  logic        clk,
    input  logic        rst_n,
    // stream input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_in
    // stream output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sample_out
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import svf_pkg::*;

    typedef enum logic [20:0] {
        ST_IDLE = 21'h000001,
        ST_IT0  = 21'h000002,
        ST_IT1  = 21'h000004,
        ST_IT2  = 21'h000008,
        ST_IT3  = 21'h000010,
        ST_IT4  = 21'h000020,
        ST_IT5  = 21'h000040,
        ST_IT6  = 21'h000080,
        ST_IT7  = 21'h000100,
        ST_TAP  = 21'h000200,
        ST_MX0  = 21'h000400,
        ST_MX1  = 21'h000800,
        ST_MX2  = 21'h001000,
        ST_MX3  = 21'h002000,
        ST_MX4  = 21'h004000,
        ST_MX5  = 21'h008000,
        ST_MX6  = 21'h010000,
        ST_MX7  = 21'h020000,
        ST_HALF = 21'h040000,
        ST_FIN  = 21'h080000,
        ST_DONE = 21'h100000
    } state_t;

    cfg_t cfg;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;          // set during the second oversampled pass
    logic   out_valid_reg, out_valid_next;

    // filter state
    logic signed [31:0] low_reg, low_next;
    logic signed [31:0] band_reg, band_next;
    logic signed [31:0] high_reg, high_next;

    // working registers
    logic signed [31:0] x_reg, x_next;          // held input sample
    logic signed [31:0] t_reg, t_next;          // scratch value
    logic signed [31:0] acc_reg, acc_next;      // tap or mix result
    logic signed [31:0] first_reg, first_next;  // halved first-pass result
    logic [31:0]        out_data_reg, out_data_next;

    alu_op_t            op;
    logic signed [31:0] opa;
    logic signed [31:0] opb;
    logic signed [31:0] res;

    logic [2:0] sel;
    logic       mix_sel;
    logic       in_fire;

    assign sel     = cfg.output_mode[3:1];
    assign mix_sel = !(sel == SEL_LOW || sel == SEL_HIGH || sel == SEL_BAND ||
                       sel == SEL_NOTCH);
    assign in_fire = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    svf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    svf_alu u_alu (
        .op  (op),
        .a   (opa),
        .b   (opb),
        .res (res)
    );

    // operand selection for the shared unit
    always_comb
    begin
        op  = OP_ADD;
        opa = '0;
        opb = '0;
        unique case (state_reg)
            ST_IT0: begin op = OP_MUL; opa = cfg.cutoff_coeff; opb = band_reg; end
            ST_IT1: begin op = OP_ADD; opa = low_reg; opb = t_reg; end
            ST_IT2:
            begin
                op  = OP_MUL;
                opa = $signed({1'b0, cfg.damping_mantissa});
                opb = band_reg;
            end
            ST_IT3:
            begin
                op  = OP_ASR;
                opa = t_reg;
                opb = $signed({27'd0, cfg.damping_shift});
            end
            ST_IT4: begin op = OP_SUB; opa = x_reg; opb = t_reg; end
            ST_IT5: begin op = OP_SUB; opa = t_reg; opb = low_reg; end
            ST_IT6: begin op = OP_MUL; opa = cfg.cutoff_coeff; opb = high_reg; end
            ST_IT7: begin op = OP_ADD; opa = band_reg; opb = t_reg; end
            ST_TAP:
            begin
                // single tap passes through as tap + 0, notch is low + high
                op = OP_ADD;
                priority if (sel == SEL_HIGH)
                begin
                    opa = high_reg;
                end
                else if (sel == SEL_BAND)
                begin
                    opa = band_reg;
                end
                else
                begin
                    opa = low_reg;
                end
                opb = (sel == SEL_NOTCH) ? high_reg : 32'sd0;
            end
            ST_MX0: begin op = OP_MUL; opa = low_reg; opb = cfg.gain_lowpass; end
            ST_MX1: begin op = OP_MUL; opa = high_reg; opb = cfg.gain_highpass; end
            ST_MX2: begin op = OP_ADD; opa = acc_reg; opb = t_reg; end
            ST_MX3: begin op = OP_MUL; opa = band_reg; opb = cfg.gain_bandpass; end
            ST_MX4: begin op = OP_ADD; opa = acc_reg; opb = t_reg; end
            ST_MX5: begin op = OP_ADD; opa = low_reg; opb = high_reg; end
            ST_MX6: begin op = OP_MUL; opa = t_reg; opb = cfg.gain_notch; end
            ST_MX7: begin op = OP_ADD; opa = acc_reg; opb = t_reg; end
            ST_HALF: begin op = OP_ASR; opa = acc_reg; opb = 32'sd1; end
            ST_FIN: begin op = OP_ADD; opa = first_reg; opb = t_reg; end
            default:
            begin
                op  = OP_ADD;
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // sequencer and register updates
    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg;
        low_next       = low_reg;
        band_next      = band_reg;
        high_next      = high_reg;
        x_next         = x_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        first_next     = first_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    x_next     = s_axis_tdata;
                    pass_next  = 1'b0;
                    state_next = ST_IT0;
                end
            end
            ST_IT0: begin t_next = res; state_next = ST_IT1; end
            ST_IT1: begin low_next = res; state_next = ST_IT2; end
            ST_IT2: begin t_next = res; state_next = ST_IT3; end
            ST_IT3: begin t_next = res; state_next = ST_IT4; end
            ST_IT4: begin t_next = res; state_next = ST_IT5; end
            ST_IT5: begin high_next = res; state_next = ST_IT6; end
            ST_IT6: begin t_next = res; state_next = ST_IT7; end
            ST_IT7:
            begin
                band_next  = res;
                state_next = mix_sel ? ST_MX0 : ST_TAP;
            end
            ST_TAP:
            begin
                acc_next   = res;
                state_next = cfg.output_mode[0] ? ST_HALF : ST_DONE;
            end
            ST_MX0: begin acc_next = res; state_next = ST_MX1; end
            ST_MX1: begin t_next = res; state_next = ST_MX2; end
            ST_MX2: begin acc_next = res; state_next = ST_MX3; end
            ST_MX3: begin t_next = res; state_next = ST_MX4; end
            ST_MX4: begin acc_next = res; state_next = ST_MX5; end
            ST_MX5: begin t_next = res; state_next = ST_MX6; end
            ST_MX6: begin t_next = res; state_next = ST_MX7; end
            ST_MX7:
            begin
                acc_next   = res;
                state_next = cfg.output_mode[0] ? ST_HALF : ST_DONE;
            end
            ST_HALF:
            begin
                // first pass: keep half and run the second iteration
                if (pass_reg)
                begin
                    t_next     = res;
                    state_next = ST_FIN;
                end
                else
                begin
                    first_next = res;
                    pass_next  = 1'b1;
                    state_next = ST_IT0;
                end
            end
            ST_FIN:
            begin
                acc_next   = res;
                pass_next  = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                pass_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            low_reg       <= '0;
            band_reg      <= '0;
            high_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
            low_reg       <= low_next;
            band_reg      <= band_next;
            high_reg      <= high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        t_reg        <= t_next;
        acc_reg      <= acc_next;
        first_reg    <= first_next;
        out_data_reg <= out_data_next;
    end

    // an accepted word always starts a fresh iteration
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_IT0 && !pass_reg))
        else $error("accepted word did not start an iteration");

    // a finished result reaches the output register in the next cycle
    a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || m_axis_tready))
        |=> (m_axis_tvalid && state_reg == ST_IDLE))
        else $error("result not delivered");

    // the final average only happens on the second pass
    a_fin_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> pass_reg)
        else $error("average without second pass");

    // the pass flag never survives into idle
    a_idle_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pass_reg)
        else $error("pass flag left set");

    // a waiting result is never overwritten by the sequencer
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !m_axis_tready) |=>
        (state_reg == ST_DONE))
        else $error("sequencer left done while output full");

endmodule
